[hdl/dss_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dss_pkg
// Shared codes, state type and result bundle for the de-duplicating stack.
// ----------------------------------------------------------------------------
package dss_pkg;

    localparam int unsigned KindW   = 2;
    localparam int unsigned StatW   = 2;
    localparam int unsigned DataW   = 32;
    localparam int unsigned CountW  = 5;

    localparam logic [KindW-1:0] KIND_PUSH   = 2'd0;
    localparam logic [KindW-1:0] KIND_POP    = 2'd1;
    localparam logic [KindW-1:0] KIND_SEARCH = 2'd2;

    localparam logic [StatW-1:0] STAT_OK    = 2'd0;
    localparam logic [StatW-1:0] STAT_DUP   = 2'd1;
    localparam logic [StatW-1:0] STAT_EMPTY = 2'd2;
    localparam logic [StatW-1:0] STAT_FULL  = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY,
        S_POP_RD,
        S_DONE
    } t_state;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

    typedef struct packed {
        logic [StatW-1:0]         status;
        logic                     found;
        logic signed [DataW-1:0]  top_value;
        logic signed [DataW-1:0]  bottom_value;
        logic [CountW-1:0]        entry_count;
        logic                     is_empty;
    } t_result;

endpackage
`default_nettype wire

[hdl/dedup_stack_with_search_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dedup_stack_with_search_unit
// Bounded LIFO of signed 32-bit values that refuses duplicate pushes.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+---------------------------
//  in      | sink      | i_in_valid / o_in_ready    | i_kind, i_value
//  out     | source    | o_out_valid / i_out_ready  | o_status, o_found,
//          |           |                            | o_top_value, o_bottom_value,
//          |           |                            | o_entry_count, o_is_empty
//
//  Push and search scan the stored entries (one memory read per
//  stored entry, one trailing compare), stopping the scan early on a hit,
//  then take one update and one hand-off step; the result loads as the
//  sequencer returns to idle for the next beat. Pop and the unused kind skip
//  the scan; a pop that must fetch the new top adds a read step. The single
//  read port of the entry memory, feeding one comparator, sets the scan length.
//  Reset clears the fill level and the sequencer; entries need no clearing.
//  A stalled output beat holds in the output register; the next input beat is
//  still accepted and its result waits in the sequencer until the slot frees.
// ----------------------------------------------------------------------------
module dedup_stack_with_search_unit #(
    parameter int unsigned DEPTH = 16
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_ready,
    input  wire [dss_pkg::KindW-1:0]         i_kind,
    input  wire signed [dss_pkg::DataW-1:0]  i_value,
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output logic [dss_pkg::StatW-1:0]        o_status,
    output logic                             o_found,
    output logic signed [dss_pkg::DataW-1:0] o_top_value,
    output logic signed [dss_pkg::DataW-1:0] o_bottom_value,
    output logic [dss_pkg::CountW-1:0]       o_entry_count,
    output logic                             o_is_empty
);

    // address width of the entry memory and width of the fill counter
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    dss_pkg::t_mem_ctl          mem_ctl;
    logic [AW-1:0]              wr_addr;
    logic [AW-1:0]              rd_addr;
    logic [dss_pkg::DataW-1:0]  wr_data;
    logic [dss_pkg::DataW-1:0]  rd_data;
    logic                       seq_idle;
    logic                       res_valid;
    dss_pkg::t_result           res;
    logic                       out_free;

    logic                       r_out_valid, n_out_valid;
    dss_pkg::t_result           r_out, n_out;

    // the output slot is free when empty or draining this cycle
    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = seq_idle;

    dss_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    dss_seq #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_in_valid && seq_idle),
        .i_kind      (i_kind),
        .i_value     (i_value),
        .i_out_free  (out_free),
        .i_rd_data   (rd_data),
        .o_idle      (seq_idle),
        .o_mem_ctl   (mem_ctl),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_addr   (rd_addr),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // output register: load a finished result, drop valid once taken
    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (res_valid) begin
            n_out_valid = 1'b1;
            n_out       = res;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out.status;
    assign o_found        = r_out.found;
    assign o_top_value    = r_out.top_value;
    assign o_bottom_value = r_out.bottom_value;
    assign o_entry_count  = r_out.entry_count;
    assign o_is_empty     = r_out.is_empty;

    // one item at a time: after an accept the input side closes
    a_busy_after_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while sequencer busy");

    // an empty stack reports zero top and bottom
    a_empty_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_empty) |-> (o_top_value == 0 && o_bottom_value == 0))
        else $error("empty result carries stale entries");

    // a duplicate rejection always comes with a hit
    a_dup_found : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == dss_pkg::STAT_DUP) |-> o_found)
        else $error("duplicate status without found flag");

    // a result is only loaded into a free slot
    a_no_overwrite : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid) |-> out_free)
        else $error("result overwrote a pending beat");

endmodule
`default_nettype wire

[hdl/dss_mem.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dss_mem
// Entry storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dss_mem #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = 4
) (
    input  wire                           i_clk,
    input  wire dss_pkg::t_mem_ctl        i_ctl,
    input  wire [AW-1:0]                  i_wr_addr,
    input  wire [dss_pkg::DataW-1:0]      i_wr_data,
    input  wire [AW-1:0]                  i_rd_addr,
    output logic [dss_pkg::DataW-1:0]     o_rd_data
);

    logic [dss_pkg::DataW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

[hdl/dss_seq.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dss_seq
// Sequencer: scans entries through the shared comparator, then applies the
// push or pop and builds the result beat.
// ----------------------------------------------------------------------------
module dss_seq #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = 4,
    parameter int unsigned CW    = 5
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_start,
    input  wire [dss_pkg::KindW-1:0]         i_kind,
    input  wire signed [dss_pkg::DataW-1:0]  i_value,
    input  wire                              i_out_free,
    input  wire [dss_pkg::DataW-1:0]         i_rd_data,
    output logic                             o_idle,
    output dss_pkg::t_mem_ctl                o_mem_ctl,
    output logic [AW-1:0]                    o_wr_addr,
    output logic [dss_pkg::DataW-1:0]        o_wr_data,
    output logic [AW-1:0]                    o_rd_addr,
    output logic                             o_res_valid,
    output dss_pkg::t_result                 o_res
);

    localparam logic [CW-1:0] FullLevel = CW'(DEPTH);
    localparam logic [CW-1:0] One       = CW'(1);

    dss_pkg::t_state                r_state, n_state;
    logic [dss_pkg::KindW-1:0]      r_kind, n_kind;
    logic [dss_pkg::DataW-1:0]      r_value, n_value;
    logic [CW-1:0]                  r_idx, n_idx;
    logic                           r_cmp_v, n_cmp_v;
    logic [CW-1:0]                  r_fill, n_fill;
    logic [dss_pkg::DataW-1:0]      r_top, n_top;
    logic [dss_pkg::DataW-1:0]      r_bottom, n_bottom;
    logic [dss_pkg::StatW-1:0]      r_status, n_status;
    logic                           r_found, n_found;
    logic [31:0]                    fill_ext;
    logic                           hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dss_pkg::S_IDLE;
            r_fill  <= '0;
            r_cmp_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_cmp_v <= n_cmp_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_value  <= n_value;
        r_idx    <= n_idx;
        r_top    <= n_top;
        r_bottom <= n_bottom;
        r_status <= n_status;
        r_found  <= n_found;
    end

    assign hit      = r_cmp_v && (i_rd_data == r_value);
    assign fill_ext = 32'(r_fill);

    always_comb begin
        n_state   = r_state;
        n_kind    = r_kind;
        n_value   = r_value;
        n_idx     = r_idx;
        n_cmp_v   = 1'b0;
        n_fill    = r_fill;
        n_top     = r_top;
        n_bottom  = r_bottom;
        n_status  = r_status;
        n_found   = r_found;
        o_mem_ctl = '0;
        o_wr_addr = r_fill[AW-1:0];
        o_wr_data = r_value;
        o_rd_addr = r_idx[AW-1:0];
        o_res_valid = 1'b0;
        o_idle    = (r_state == dss_pkg::S_IDLE);

        o_res.status       = r_status;
        o_res.found        = r_found;
        o_res.top_value    = (r_fill == '0) ? '0 : r_top;
        o_res.bottom_value = (r_fill == '0) ? '0 : r_bottom;
        o_res.entry_count  = fill_ext[dss_pkg::CountW-1:0];
        o_res.is_empty     = (r_fill == '0);

        unique case (r_state)
            dss_pkg::S_IDLE: begin
                if (i_start) begin
                    n_kind   = i_kind;
                    n_value  = i_value;
                    n_idx    = '0;
                    n_found  = 1'b0;
                    n_status = dss_pkg::STAT_OK;
                    if (i_kind == dss_pkg::KIND_PUSH || i_kind == dss_pkg::KIND_SEARCH) begin
                        n_state = dss_pkg::S_SCAN;
                    end else begin
                        n_state = dss_pkg::S_APPLY;
                    end
                end
            end
            dss_pkg::S_SCAN: begin
                // compare the entry read last cycle while issuing the next read
                if (hit) begin
                    n_found = 1'b1;
                    n_state = dss_pkg::S_APPLY;
                end else if (r_idx < r_fill) begin
                    o_mem_ctl.rd_en = 1'b1;
                    n_idx   = r_idx + One;
                    n_cmp_v = 1'b1;
                end else begin
                    n_state = dss_pkg::S_APPLY;
                end
            end
            dss_pkg::S_APPLY: begin
                n_state = dss_pkg::S_DONE;
                case (r_kind)
                    dss_pkg::KIND_PUSH: begin
                        if (r_found) begin
                            n_status = dss_pkg::STAT_DUP;
                        end else if (r_fill == FullLevel) begin
                            n_status = dss_pkg::STAT_FULL;
                        end else begin
                            o_mem_ctl.wr_en = 1'b1;
                            n_fill = r_fill + One;
                            n_top  = r_value;
                            if (r_fill == '0) begin
                                n_bottom = r_value;
                            end
                        end
                    end
                    dss_pkg::KIND_POP: begin
                        if (r_fill == '0) begin
                            n_status = dss_pkg::STAT_EMPTY;
                        end else begin
                            n_fill = r_fill - One;
                            if (r_fill > One) begin
                                // fetch the entry that becomes the new top
                                o_mem_ctl.rd_en = 1'b1;
                                o_rd_addr = AW'(r_fill - One - One);
                                n_state   = dss_pkg::S_POP_RD;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            dss_pkg::S_POP_RD: begin
                n_top   = i_rd_data;
                n_state = dss_pkg::S_DONE;
            end
            dss_pkg::S_DONE: begin
                if (i_out_free) begin
                    o_res_valid = 1'b1;
                    n_state     = dss_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dss_pkg::S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire
